// File: hdl/smeu_pkg.sv
// Shared types and opcode constants for the stack machine execute unit.
package smeu_pkg;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] operand_value;
        logic [7:0] effective_addr;
        logic [7:0] next_pc;
    } in_t;

    typedef struct packed {
        logic       pc_load;
        logic [7:0] pc_value;
        logic       mem_write;
        logic [7:0] mem_addr;
        logic [7:0] mem_data;
        logic       skip_next;
        logic       halted;
        logic [7:0] stack_top;
        logic [5:0] stack_pointer;
    } out_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ALU2,
        OP_ALU1,
        OP_CLR,
        OP_TEST1,
        OP_TEST2,
        OP_RTS,
        OP_PSH,
        OP_POP,
        OP_JMP,
        OP_JSR,
        OP_HLT
    } op_kind_t;

    typedef enum logic [3:0] {
        FN_ADD,
        FN_SUB,
        FN_AND,
        FN_OR,
        FN_NOT,
        FN_NEG,
        FN_INC,
        FN_DEC,
        FN_ASR,
        FN_ASL,
        FN_ROR,
        FN_ROL
    } alu_fn_t;

    typedef enum logic [2:0] {
        C_EQ,
        C_NE,
        C_GT,
        C_LT,
        C_GE,
        C_LE
    } cond_t;

    typedef struct packed {
        op_kind_t   kind;
        alu_fn_t    fn;
        cond_t      cond;
        logic [7:0] operand_value;
        logic [7:0] effective_addr;
        logic [7:0] next_pc;
    } item_t;

    localparam logic [7:0] OPC_ADD = 8'h11;
    localparam logic [7:0] OPC_SUB = 8'h12;
    localparam logic [7:0] OPC_AND = 8'h13;
    localparam logic [7:0] OPC_OR  = 8'h14;
    localparam logic [7:0] OPC_CLR = 8'h21;
    localparam logic [7:0] OPC_NOT = 8'h22;
    localparam logic [7:0] OPC_NEG = 8'h23;
    localparam logic [7:0] OPC_INC = 8'h24;
    localparam logic [7:0] OPC_DEC = 8'h25;
    localparam logic [7:0] OPC_ASR = 8'h31;
    localparam logic [7:0] OPC_ASL = 8'h32;
    localparam logic [7:0] OPC_ROR = 8'h33;
    localparam logic [7:0] OPC_ROL = 8'h34;
    localparam logic [7:0] OPC_SZ  = 8'h41;
    localparam logic [7:0] OPC_SNZ = 8'h42;
    localparam logic [7:0] OPC_SPL = 8'h43;
    localparam logic [7:0] OPC_SMI = 8'h44;
    localparam logic [7:0] OPC_SPZ = 8'h45;
    localparam logic [7:0] OPC_SMZ = 8'h46;
    localparam logic [7:0] OPC_SEQ = 8'h51;
    localparam logic [7:0] OPC_SNE = 8'h52;
    localparam logic [7:0] OPC_SGR = 8'h53;
    localparam logic [7:0] OPC_SLS = 8'h54;
    localparam logic [7:0] OPC_SGE = 8'h55;
    localparam logic [7:0] OPC_SLE = 8'h56;
    localparam logic [7:0] OPC_RTS = 8'h66;

    localparam logic [5:0] PFX_PSH = 6'h1C;
    localparam logic [5:0] PFX_POP = 6'h20;
    localparam logic [5:0] PFX_JMP = 6'h24;
    localparam logic [5:0] PFX_JSR = 6'h28;
    localparam logic [3:0] PFX_HLT = 4'hF;

endpackage

// File: hdl/smeu_front.sv
// Front end: accepts opcode beats, decodes them and buffers them in a two-entry queue.
module smeu_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  smeu_pkg::in_t   s_payload,
    output logic            q_valid,
    input  logic            q_ready,
    output smeu_pkg::item_t q_item
);
    import smeu_pkg::*;

    localparam logic [1:0] QUEUE_FULL = 2'd2;

    item_t      ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    item_t      dec_item;

    function automatic item_t decode(input in_t b);
        item_t it;
        it.kind           = OP_NOP;
        it.fn             = FN_ADD;
        it.cond           = C_EQ;
        it.operand_value  = b.operand_value;
        it.effective_addr = b.effective_addr;
        it.next_pc        = b.next_pc;
        case (b.cmd)
            OPC_ADD: begin it.kind = OP_ALU2; it.fn = FN_ADD; end
            OPC_SUB: begin it.kind = OP_ALU2; it.fn = FN_SUB; end
            OPC_AND: begin it.kind = OP_ALU2; it.fn = FN_AND; end
            OPC_OR:  begin it.kind = OP_ALU2; it.fn = FN_OR;  end
            OPC_CLR: it.kind = OP_CLR;
            OPC_NOT: begin it.kind = OP_ALU1; it.fn = FN_NOT; end
            OPC_NEG: begin it.kind = OP_ALU1; it.fn = FN_NEG; end
            OPC_INC: begin it.kind = OP_ALU1; it.fn = FN_INC; end
            OPC_DEC: begin it.kind = OP_ALU1; it.fn = FN_DEC; end
            OPC_ASR: begin it.kind = OP_ALU1; it.fn = FN_ASR; end
            OPC_ASL: begin it.kind = OP_ALU1; it.fn = FN_ASL; end
            OPC_ROR: begin it.kind = OP_ALU1; it.fn = FN_ROR; end
            OPC_ROL: begin it.kind = OP_ALU1; it.fn = FN_ROL; end
            OPC_SZ:  begin it.kind = OP_TEST1; it.cond = C_EQ; end
            OPC_SNZ: begin it.kind = OP_TEST1; it.cond = C_NE; end
            OPC_SPL: begin it.kind = OP_TEST1; it.cond = C_GT; end
            OPC_SMI: begin it.kind = OP_TEST1; it.cond = C_LT; end
            OPC_SPZ: begin it.kind = OP_TEST1; it.cond = C_GE; end
            OPC_SMZ: begin it.kind = OP_TEST1; it.cond = C_LE; end
            OPC_SEQ: begin it.kind = OP_TEST2; it.cond = C_EQ; end
            OPC_SNE: begin it.kind = OP_TEST2; it.cond = C_NE; end
            OPC_SGR: begin it.kind = OP_TEST2; it.cond = C_GT; end
            OPC_SLS: begin it.kind = OP_TEST2; it.cond = C_LT; end
            OPC_SGE: begin it.kind = OP_TEST2; it.cond = C_GE; end
            OPC_SLE: begin it.kind = OP_TEST2; it.cond = C_LE; end
            OPC_RTS: it.kind = OP_RTS;
            default: begin
                if (b.cmd[7:2] == PFX_PSH) begin
                    it.kind = OP_PSH;
                end else if (b.cmd[7:2] == PFX_POP) begin
                    it.kind = OP_POP;
                end else if (b.cmd[7:2] == PFX_JMP) begin
                    it.kind = OP_JMP;
                end else if (b.cmd[7:2] == PFX_JSR) begin
                    it.kind = OP_JSR;
                end else if (b.cmd[7:4] == PFX_HLT) begin
                    it.kind = OP_HLT;
                end
            end
        endcase
        return it;
    endfunction

    assign dec_item = decode(s_payload);
    assign s_ready  = (cnt_reg != QUEUE_FULL);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];
    assign push     = s_valid && s_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

// File: hdl/smeu_back.sv
// Back end: executes decoded instructions against the stack and registers each result beat.
module smeu_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  smeu_pkg::item_t q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output smeu_pkg::out_t  m_payload
);
    import smeu_pkg::*;

    localparam int         PW      = $clog2(STACK_DEPTH);
    localparam logic [PW:0] DEPTH_W = (PW + 1)'(STACK_DEPTH);
    localparam logic [PW:0] OFS1    = (PW + 1)'(1 % STACK_DEPTH);
    localparam logic [PW:0] OFS2    = (PW + 1)'(2 % STACK_DEPTH);
    localparam logic [PW:0] OFS3    = (PW + 1)'(3 % STACK_DEPTH);

    logic [7:0]             mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] vld_reg;
    logic [PW-1:0]          sp_reg;
    logic [PW-1:0]          sp_next;
    logic [7:0]             t0_reg;
    logic [7:0]             t0_next;
    logic [7:0]             t1_reg;
    logic [7:0]             t1_next;
    logic [7:0]             t2_reg;
    logic [7:0]             t3_reg;
    logic                   m_valid_reg;
    out_t                   m_data_reg;
    out_t                   res;
    logic                   fire;
    logic                   wr_en;
    logic [PW-1:0]          wr_addr;
    logic [7:0]             wr_data;
    logic [PW-1:0]          rd2_addr;
    logic [PW-1:0]          rd3_addr;
    logic [PW-1:0]          sp_m1;
    logic [PW-1:0]          sp_m2;
    logic [PW-1:0]          sp_p1;
    logic [7:0]             alu_res;
    logic [7:0]             cmp_lhs;
    logic [7:0]             cmp_rhs;
    logic                   hit;

    function automatic logic [PW-1:0] ptr_sub(input logic [PW-1:0] p, input logic [PW:0] k);
        logic [PW:0] w;
        w = {1'b0, p};
        if (w >= k) begin
            w = w - k;
        end else begin
            w = w + DEPTH_W - k;
        end
        return w[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW:0] w;
        w = {1'b0, p} + (PW + 1)'(1);
        if (w == DEPTH_W) begin
            w = '0;
        end
        return w[PW-1:0];
    endfunction

    assign q_ready   = !m_valid_reg || m_ready;
    assign fire      = q_valid && q_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    assign sp_m1 = ptr_sub(sp_reg, OFS1);
    assign sp_m2 = ptr_sub(sp_reg, OFS2);
    assign sp_p1 = ptr_inc(sp_reg);

    always_comb begin
        case (q_item.fn)
            FN_ADD:  alu_res = t1_reg + t0_reg;
            FN_SUB:  alu_res = t1_reg - t0_reg;
            FN_AND:  alu_res = t1_reg & t0_reg;
            FN_OR:   alu_res = t1_reg | t0_reg;
            FN_NOT:  alu_res = ~t0_reg;
            FN_NEG:  alu_res = 8'h00 - t0_reg;
            FN_INC:  alu_res = t0_reg + 8'h01;
            FN_DEC:  alu_res = t0_reg - 8'h01;
            FN_ASR:  alu_res = {t0_reg[7], t0_reg[7:1]};
            FN_ASL:  alu_res = {t0_reg[6:0], 1'b0};
            FN_ROR:  alu_res = {t0_reg[0], t0_reg[7:1]};
            FN_ROL:  alu_res = {t0_reg[6:0], t0_reg[7]};
            default: alu_res = 8'h00;
        endcase
    end

    // One-operand tests compare the popped byte against zero.
    always_comb begin
        if (q_item.kind == OP_TEST2) begin
            cmp_lhs = t1_reg;
            cmp_rhs = t0_reg;
        end else begin
            cmp_lhs = t0_reg;
            cmp_rhs = 8'h00;
        end
        case (q_item.cond)
            C_EQ:    hit = (cmp_lhs == cmp_rhs);
            C_NE:    hit = (cmp_lhs != cmp_rhs);
            C_GT:    hit = ($signed(cmp_lhs) > $signed(cmp_rhs));
            C_LT:    hit = ($signed(cmp_lhs) < $signed(cmp_rhs));
            C_GE:    hit = ($signed(cmp_lhs) >= $signed(cmp_rhs));
            C_LE:    hit = ($signed(cmp_lhs) <= $signed(cmp_rhs));
            default: hit = 1'b0;
        endcase
    end

    // The top two stack bytes live in registers; the next two are read ahead from memory.
    always_comb begin
        sp_next = sp_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        wr_en   = 1'b0;
        wr_addr = sp_reg;
        wr_data = alu_res;
        res     = '0;
        if (fire) begin
            case (q_item.kind)
                OP_ALU2: begin
                    sp_next = sp_m1;
                    wr_en   = 1'b1;
                    wr_addr = sp_m1;
                    t0_next = alu_res;
                    t1_next = t2_reg;
                end
                OP_ALU1: begin
                    wr_en   = 1'b1;
                    t0_next = alu_res;
                end
                OP_CLR: begin
                    wr_en   = 1'b1;
                    wr_data = 8'h00;
                    t0_next = 8'h00;
                end
                OP_TEST1: begin
                    sp_next       = sp_m1;
                    t0_next       = t1_reg;
                    t1_next       = t2_reg;
                    res.skip_next = hit;
                end
                OP_TEST2: begin
                    sp_next       = sp_m2;
                    t0_next       = t2_reg;
                    t1_next       = t3_reg;
                    res.skip_next = hit;
                end
                OP_RTS: begin
                    sp_next      = sp_m1;
                    t0_next      = t1_reg;
                    t1_next      = t2_reg;
                    res.pc_load  = 1'b1;
                    res.pc_value = t0_reg;
                end
                OP_POP: begin
                    sp_next       = sp_m1;
                    t0_next       = t1_reg;
                    t1_next       = t2_reg;
                    res.mem_write = 1'b1;
                    res.mem_addr  = q_item.effective_addr;
                    res.mem_data  = t0_reg;
                end
                OP_PSH: begin
                    sp_next = sp_p1;
                    wr_en   = 1'b1;
                    wr_addr = sp_p1;
                    wr_data = q_item.operand_value;
                    t0_next = q_item.operand_value;
                    t1_next = t0_reg;
                end
                OP_JSR: begin
                    sp_next      = sp_p1;
                    wr_en        = 1'b1;
                    wr_addr      = sp_p1;
                    wr_data      = q_item.next_pc;
                    t0_next      = q_item.next_pc;
                    t1_next      = t0_reg;
                    res.pc_load  = 1'b1;
                    res.pc_value = q_item.effective_addr;
                end
                OP_JMP: begin
                    res.pc_load  = 1'b1;
                    res.pc_value = q_item.effective_addr;
                end
                OP_HLT: begin
                    res.halted = 1'b1;
                end
                default: begin
                end
            endcase
        end
        res.stack_top     = t0_next;
        res.stack_pointer = 6'(sp_next);
    end

    assign rd2_addr = ptr_sub(sp_next, OFS2);
    assign rd3_addr = ptr_sub(sp_next, OFS3);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data bypasses the write of the same cycle; unwritten entries read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            t2_reg  <= 8'h00;
            t3_reg  <= 8'h00;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_en && (wr_addr == rd2_addr)) begin
                t2_reg <= wr_data;
            end else begin
                t2_reg <= vld_reg[rd2_addr] ? mem[rd2_addr] : 8'h00;
            end
            if (wr_en && (wr_addr == rd3_addr)) begin
                t3_reg <= wr_data;
            end else begin
                t3_reg <= vld_reg[rd3_addr] ? mem[rd3_addr] : 8'h00;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            t0_reg      <= 8'h00;
            t1_reg      <= 8'h00;
            m_valid_reg <= 1'b0;
        end else begin
            sp_reg <= sp_next;
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= res;
        end
    end

endmodule

// File: hdl/stack_machine_execute_unit_top.sv
// Top level of the stack machine execute unit.
//
// The s_ channel takes one instruction beat: opcode, fetched operand, effective
// address and the address of the following instruction. The m_ channel returns
// one result beat per instruction: PC load, memory write, skip and halt flags,
// plus the stack top byte and stack pointer left by that instruction.
// An accepted beat is registered in the decode queue, then in the output register.
// One instruction is executed per cycle while the output register is free or its
// beat is taken. The rate is set by the execute stage, which holds the top two
// stack bytes in registers and refills the two bytes below them each cycle through
// two registered read ports of the stack memory. A two-entry decode queue sits
// between the front and the execute stage, and the result sits in an output
// register, so s_ready stays high while a result waits, until the queue is full.
// When the receiver stalls, the queue fills and s_ready drops once it holds two
// beats. Reset clears the stack to zero, the pointer to zero, and empties the
// queue and the output register; no reset sweep is needed.
module stack_machine_execute_unit_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  smeu_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output smeu_pkg::out_t m_payload
);
    import smeu_pkg::*;

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    smeu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    smeu_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_accept_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> q_valid)
        else $error("Accepted beat did not reach the decode queue.");

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !q_valid |=> !m_valid)
        else $error("Result beat appeared without a queued instruction.");

    a_exclusive_effects: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_payload.pc_load && m_payload.mem_write)
                    && !(m_payload.halted && (m_payload.pc_load || m_payload.skip_next)))
        else $error("Result beat carries conflicting effects.");

endmodule

// File: dv/stack_machine_execute_unit_top_tb.sv
// Self-checking testbench for the stack machine execute unit top level.
`timescale 1ns / 100ps

module stack_machine_execute_unit_top_tb;
    import smeu_pkg::*;

    localparam int DIR_ROWS = 37;
    localparam int RND_ITEMS = 1513;
    localparam int CALM_ITEMS = 150;
    localparam int LONG_HOLD = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        in_t  din;
        logic typed;
        out_t want;
    } dir_row_t;

    localparam logic [7:0] FIXED_OPS [26] = '{
        OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_CLR, OPC_NOT, OPC_NEG, OPC_INC,
        OPC_DEC, OPC_ASR, OPC_ASL, OPC_ROR, OPC_ROL, OPC_SZ, OPC_SNZ, OPC_SPL,
        OPC_SMI, OPC_SPZ, OPC_SMZ, OPC_SEQ, OPC_SNE, OPC_SGR, OPC_SLS, OPC_SGE,
        OPC_SLE, OPC_RTS
    };

    localparam logic [7:0] EDGE_BYTES [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};

    // The first rows start from the cleared stack, so their results are typed in.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{8'h00, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 6'd0}},
        '{'{{PFX_PSH, 2'b00}, 8'hFF, 8'h5A, 8'hA5}, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'hFF, 6'd1}},
        '{'{{PFX_PSH, 2'b11}, 8'h02, 8'hA5, 8'h5A}, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h02, 6'd2}},
        '{'{OPC_ADD, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h01, 6'd1}},
        '{'{{PFX_POP, 2'b01}, 8'h00, 8'hFF, 8'h00}, 1'b1,
          '{1'b0, 8'h00, 1'b1, 8'hFF, 8'h01, 1'b0, 1'b0, 8'h00, 6'd0}},
        '{'{{PFX_POP, 2'b10}, 8'hFF, 8'h00, 8'hFF}, 1'b1,
          '{1'b0, 8'h00, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 6'd63}},
        '{'{{PFX_JSR, 2'b11}, 8'h00, 8'hFF, 8'hAB}, 1'b1,
          '{1'b1, 8'hFF, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'hAB, 6'd0}},
        '{'{OPC_RTS, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
          '{1'b1, 8'hAB, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 6'd63}},
        '{'{{PFX_JMP, 2'b00}, 8'hFF, 8'h00, 8'hFF}, 1'b1,
          '{1'b1, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 6'd63}},
        '{'{8'hF3, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 6'd63}},
        '{'{8'h15, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 6'd63}},
        '{'{{PFX_PSH, 2'b01}, 8'h80, 8'h00, 8'h00}, 1'b0, '0},
        '{'{{PFX_PSH, 2'b10}, 8'h7F, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SGR, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SUB, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_AND, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_OR,  8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_CLR, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_NOT, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_NEG, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_INC, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_DEC, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_ASR, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_ASL, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_ROR, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_ROL, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SZ,  8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SNZ, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SPL, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SMI, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SPZ, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SMZ, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SEQ, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SNE, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SLS, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SGE, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OPC_SLE, 8'h00, 8'h00, 8'h00}, 1'b0, '0}
    };

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;

    logic [7:0]  stack_img [64];
    logic [5:0]  sp_img;
    out_t        pending_results [$];
    int unsigned mismatches;
    int unsigned result_count;
    int unsigned quiet_cycles;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned push_pct;
    logic        calm;
    logic        long_hold_req;
    out_t        want_r;

    stack_machine_execute_unit_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void push_byte(logic [7:0] v);
        sp_img = sp_img + 6'd1;
        stack_img[sp_img] = v;
    endfunction

    function automatic logic [7:0] pop_byte();
        logic [7:0] v;
        v = stack_img[sp_img];
        sp_img = sp_img - 6'd1;
        return v;
    endfunction

    function automatic out_t execute_instr(in_t ins);
        out_t r;
        logic [7:0] a;
        logic [7:0] b;
        r = '0;
        case (ins.cmd)
            OPC_ADD: begin a = pop_byte(); b = pop_byte(); push_byte(b + a); end
            OPC_SUB: begin a = pop_byte(); b = pop_byte(); push_byte(b - a); end
            OPC_AND: begin a = pop_byte(); b = pop_byte(); push_byte(b & a); end
            OPC_OR:  begin a = pop_byte(); b = pop_byte(); push_byte(b | a); end
            OPC_CLR: stack_img[sp_img] = 8'h00;
            OPC_NOT: begin a = pop_byte(); push_byte(~a); end
            OPC_NEG: begin a = pop_byte(); push_byte(8'h00 - a); end
            OPC_INC: begin a = pop_byte(); push_byte(a + 8'h01); end
            OPC_DEC: begin a = pop_byte(); push_byte(a - 8'h01); end
            OPC_ASR: begin a = pop_byte(); push_byte({a[7], a[7:1]}); end
            OPC_ASL: begin a = pop_byte(); push_byte({a[6:0], 1'b0}); end
            OPC_ROR: begin a = pop_byte(); push_byte({a[0], a[7:1]}); end
            OPC_ROL: begin a = pop_byte(); push_byte({a[6:0], a[7]}); end
            OPC_SZ:  begin a = pop_byte(); r.skip_next = (a == 8'h00); end
            OPC_SNZ: begin a = pop_byte(); r.skip_next = (a != 8'h00); end
            OPC_SPL: begin a = pop_byte(); r.skip_next = ($signed(a) > 0); end
            OPC_SMI: begin a = pop_byte(); r.skip_next = ($signed(a) < 0); end
            OPC_SPZ: begin a = pop_byte(); r.skip_next = ($signed(a) >= 0); end
            OPC_SMZ: begin a = pop_byte(); r.skip_next = ($signed(a) <= 0); end
            OPC_SEQ: begin a = pop_byte(); b = pop_byte(); r.skip_next = (b == a); end
            OPC_SNE: begin a = pop_byte(); b = pop_byte(); r.skip_next = (b != a); end
            OPC_SGR: begin
                a = pop_byte(); b = pop_byte(); r.skip_next = ($signed(b) > $signed(a));
            end
            OPC_SLS: begin
                a = pop_byte(); b = pop_byte(); r.skip_next = ($signed(b) < $signed(a));
            end
            OPC_SGE: begin
                a = pop_byte(); b = pop_byte(); r.skip_next = ($signed(b) >= $signed(a));
            end
            OPC_SLE: begin
                a = pop_byte(); b = pop_byte(); r.skip_next = ($signed(b) <= $signed(a));
            end
            OPC_RTS: begin
                r.pc_value = pop_byte();
                r.pc_load = 1'b1;
            end
            default: begin
                if (ins.cmd[7:2] == PFX_PSH) begin
                    push_byte(ins.operand_value);
                end else if (ins.cmd[7:2] == PFX_POP) begin
                    r.mem_data = pop_byte();
                    r.mem_addr = ins.effective_addr;
                    r.mem_write = 1'b1;
                end else if (ins.cmd[7:2] == PFX_JMP) begin
                    r.pc_load = 1'b1;
                    r.pc_value = ins.effective_addr;
                end else if (ins.cmd[7:2] == PFX_JSR) begin
                    push_byte(ins.next_pc);
                    r.pc_load = 1'b1;
                    r.pc_value = ins.effective_addr;
                end else if (ins.cmd[7:4] == PFX_HLT) begin
                    r.halted = 1'b1;
                end
            end
        endcase
        r.stack_top = stack_img[sp_img];
        r.stack_pointer = sp_img;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) == 0) begin
            return EDGE_BYTES[$urandom_range(0, 4)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_cmd(int unsigned pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < pct) begin
            return {PFX_PSH, 2'($urandom_range(0, 3))};
        end else if (r < pct + 8) begin
            return {PFX_POP, 2'($urandom_range(0, 3))};
        end else if (r < pct + 11) begin
            return {PFX_JMP, 2'($urandom_range(0, 3))};
        end else if (r < pct + 14) begin
            return {PFX_JSR, 2'($urandom_range(0, 3))};
        end else if (r < pct + 16) begin
            return {PFX_HLT, 4'($urandom_range(0, 15))};
        end else if (r < pct + 20) begin
            return 8'($urandom_range(0, 255));
        end
        return FIXED_OPS[$urandom_range(0, 25)];
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        if (mismatches < MAX_PRINTS) begin
            $display("result beat %0d: %s is 0x%0h, expected 0x%0h",
                     result_count, field, got, want);
        end
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(in_t din, logic typed, out_t want);
        out_t predicted;
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= din;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = execute_instr(din);
        pending_results.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    initial begin
        forever begin
            repeat (97) @(posedge aclk);
            case ($urandom_range(0, 2))
                0: tx_idle_pct = 0;
                1: tx_idle_pct = 12;
                default: tx_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: rx_idle_pct = 0;
                1: rx_idle_pct = 12;
                default: rx_idle_pct = 40;
            endcase
        end
    end

    initial begin
        int unsigned hold;
        hold = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold == 0 && long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (hold == 0 && !calm && $urandom_range(0, 99) < rx_idle_pct) begin
                hold = $urandom_range(1, 3);
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", m_payload.stack_top, 0);
            end else begin
                want_r = pending_results.pop_front();
                if (m_payload.pc_load !== want_r.pc_load)
                    report_mismatch("pc_load", m_payload.pc_load, want_r.pc_load);
                if (m_payload.pc_value !== want_r.pc_value)
                    report_mismatch("pc_value", m_payload.pc_value, want_r.pc_value);
                if (m_payload.mem_write !== want_r.mem_write)
                    report_mismatch("mem_write", m_payload.mem_write, want_r.mem_write);
                if (m_payload.mem_addr !== want_r.mem_addr)
                    report_mismatch("mem_addr", m_payload.mem_addr, want_r.mem_addr);
                if (m_payload.mem_data !== want_r.mem_data)
                    report_mismatch("mem_data", m_payload.mem_data, want_r.mem_data);
                if (m_payload.skip_next !== want_r.skip_next)
                    report_mismatch("skip_next", m_payload.skip_next, want_r.skip_next);
                if (m_payload.halted !== want_r.halted)
                    report_mismatch("halted", m_payload.halted, want_r.halted);
                if (m_payload.stack_top !== want_r.stack_top)
                    report_mismatch("stack_top", m_payload.stack_top, want_r.stack_top);
                if (m_payload.stack_pointer !== want_r.stack_pointer)
                    report_mismatch("stack_pointer", m_payload.stack_pointer,
                                    want_r.stack_pointer);
            end
            result_count++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("stack_machine_execute_unit_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int unsigned idx;
        in_t din;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        calm = 1'b0;
        long_hold_req = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_pct = 30;
        mismatches = 0;
        result_count = 0;
        quiet_cycles = 0;
        for (idx = 0; idx < 64; idx++) begin
            stack_img[idx] = 8'h00;
        end
        sp_img = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (idx = 0; idx < DIR_ROWS; idx++) begin
            send_beat(DIR_TABLE[idx].din, DIR_TABLE[idx].typed, DIR_TABLE[idx].want);
        end
        for (idx = 0; idx < RND_ITEMS; idx++) begin
            if (idx % 100 == 0) begin
                push_pct = $urandom_range(10, 60);
            end
            if (idx == 30 || idx == 800) begin
                long_hold_req = 1'b1;
            end
            calm = (idx + CALM_ITEMS >= RND_ITEMS);
            din.cmd = pick_cmd(push_pct);
            din.operand_value = rand_byte();
            din.effective_addr = rand_byte();
            din.next_pc = rand_byte();
            send_beat(din, 1'b0, '0);
        end
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("stack_machine_execute_unit_top regression: pass");
        end else begin
            $display("stack_machine_execute_unit_top regression: fail");
        end
        $finish;
    end

endmodule

// File: stack_machine_execute_unit_top.f
hdl/smeu_pkg.sv
hdl/smeu_front.sv
hdl/smeu_back.sv
hdl/stack_machine_execute_unit_top.sv
dv/stack_machine_execute_unit_top_tb.sv
